// ----- sv/sct_pkg.sv -----
// ============================================================================
// sct_pkg
// shared codes, result type and character tables for the scan-code translator
// ============================================================================
`default_nettype none

package sct_pkg;

    localparam logic [15:0] EV_KEY = 16'd1;

    localparam logic [15:0] CODE_SHIFT  = 16'd42;
    localparam logic [15:0] CODE_CTRL   = 16'd29;
    localparam logic [15:0] CODE_CTRL2  = 16'd97;
    localparam logic [15:0] CODE_WIN    = 16'd125;
    localparam logic [15:0] CODE_ALT    = 16'd56;
    localparam logic [15:0] CODE_ALTGR  = 16'd100;
    localparam logic [15:0] CODE_CAPS   = 16'd58;
    localparam logic [15:0] CODE_UP     = 16'd103;
    localparam logic [15:0] CODE_DOWN   = 16'd108;
    localparam logic [15:0] CODE_RIGHT  = 16'd106;
    localparam logic [15:0] CODE_LEFT   = 16'd105;
    localparam logic [15:0] TABLE_LEN   = 16'd58;

    localparam logic [6:0] KEY_UP    = 7'd11;
    localparam logic [6:0] KEY_DOWN  = 7'd10;
    localparam logic [6:0] KEY_RIGHT = 7'd21;
    localparam logic [6:0] KEY_LEFT  = 7'd8;

    localparam logic [6:0] FLG_SHIFT = 7'h01;
    localparam logic [6:0] FLG_CTRL  = 7'h02;
    localparam logic [6:0] FLG_CTRL2 = 7'h04;
    localparam logic [6:0] FLG_WIN   = 7'h08;
    localparam logic [6:0] FLG_ALT   = 7'h10;
    localparam logic [6:0] FLG_ALTGR = 7'h20;
    localparam logic [6:0] FLG_CAPS  = 7'h40;

    localparam logic [6:0] CASE_BIT  = 7'h20;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_DOWN = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;

    typedef struct packed {
        logic       emit;
        logic [1:0] mode;
        logic [6:0] key;
        logic [6:0] mods;
    } sct_result_t;

    function automatic logic [6:0] plain_char(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'd1:  c = 7'h1B;
            6'd2:  c = 7'h31;
            6'd3:  c = 7'h32;
            6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;
            6'd6:  c = 7'h35;
            6'd7:  c = 7'h36;
            6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;
            6'd10: c = 7'h39;
            6'd11: c = 7'h30;
            6'd12: c = 7'h2D;
            6'd13: c = 7'h3D;
            6'd14: c = 7'h7F;
            6'd15: c = 7'h09;
            6'd16: c = 7'h51;
            6'd17: c = 7'h57;
            6'd18: c = 7'h45;
            6'd19: c = 7'h52;
            6'd20: c = 7'h54;
            6'd21: c = 7'h59;
            6'd22: c = 7'h55;
            6'd23: c = 7'h49;
            6'd24: c = 7'h4F;
            6'd25: c = 7'h50;
            6'd26: c = 7'h5B;
            6'd27: c = 7'h5D;
            6'd28: c = 7'h0D;
            6'd30: c = 7'h41;
            6'd31: c = 7'h53;
            6'd32: c = 7'h44;
            6'd33: c = 7'h46;
            6'd34: c = 7'h47;
            6'd35: c = 7'h48;
            6'd36: c = 7'h4A;
            6'd37: c = 7'h4B;
            6'd38: c = 7'h4C;
            6'd39: c = 7'h3B;
            6'd40: c = 7'h27;
            6'd41: c = 7'h60;
            6'd43: c = 7'h23;
            6'd44: c = 7'h5A;
            6'd45: c = 7'h58;
            6'd46: c = 7'h43;
            6'd47: c = 7'h56;
            6'd48: c = 7'h42;
            6'd49: c = 7'h4E;
            6'd50: c = 7'h4D;
            6'd51: c = 7'h2C;
            6'd52: c = 7'h2E;
            6'd53: c = 7'h2F;
            6'd57: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // shifted layout differs from the plain one only on digit and symbol keys
    function automatic logic [6:0] shift_char(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'd2:  c = 7'h21;
            6'd3:  c = 7'h22;
            6'd4:  c = 7'h23;
            6'd5:  c = 7'h24;
            6'd6:  c = 7'h25;
            6'd7:  c = 7'h5E;
            6'd8:  c = 7'h26;
            6'd9:  c = 7'h2A;
            6'd10: c = 7'h28;
            6'd11: c = 7'h29;
            6'd12: c = 7'h5F;
            6'd13: c = 7'h2B;
            6'd26: c = 7'h7B;
            6'd27: c = 7'h7D;
            6'd39: c = 7'h3A;
            6'd40: c = 7'h40;
            6'd41: c = 7'h7E;
            6'd43: c = 7'h7E;
            6'd51: c = 7'h3C;
            6'd52: c = 7'h3E;
            6'd53: c = 7'h3F;
            default: c = plain_char(idx);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sct_decode.sv -----
// ============================================================================
// sct_decode
// translates one key event against the held modifier flags and last key
// ============================================================================
`default_nettype none

module sct_decode
    import sct_pkg::*;
(
    input  wire logic [15:0] event_type,
    input  wire logic [15:0] key_code,
    input  wire logic [7:0]  key_value,
    input  wire logic [6:0]  mods,
    input  wire logic [6:0]  last_key,
    output sct_result_t      result
);

    logic       act;
    logic       press;
    logic [1:0] mode;
    logic [6:0] mask;
    logic [6:0] chr;

    assign act   = (event_type == EV_KEY) && (key_value[7:1] == 7'd0);
    assign press = key_value[0];
    assign mode  = press ? MODE_DOWN : MODE_UP;

    always_comb
    begin
        unique case (key_code)
            CODE_SHIFT: mask = FLG_SHIFT;
            CODE_CTRL:  mask = FLG_CTRL;
            CODE_CTRL2: mask = FLG_CTRL2;
            CODE_WIN:   mask = FLG_WIN;
            CODE_ALT:   mask = FLG_ALT;
            CODE_ALTGR: mask = FLG_ALTGR;
            default:    mask = 7'h00;
        endcase
    end

    always_comb
    begin
        chr = ((mods & FLG_SHIFT) != 7'h00) ? shift_char(key_code[5:0])
                                            : plain_char(key_code[5:0]);
        // letter case follows shift or caps
        if (chr >= 7'h41 && chr <= 7'h5A)
        begin
            if ((mods & (FLG_SHIFT | FLG_CAPS)) != 7'h00)
                chr = chr & ~CASE_BIT;
            else
                chr = chr | CASE_BIT;
        end
    end

    always_comb
    begin
        result.emit = 1'b0;
        result.mode = mode;
        result.key  = last_key;
        result.mods = mods;
        if (act)
        begin
            if (mask != 7'h00)
            begin
                result.emit = 1'b1;
                result.mode = MODE_NONE;
                result.mods = press ? (mods | mask) : (mods & ~mask);
            end
            else if (key_code == CODE_CAPS)
            begin
                if (press)
                    result.mods = mods ^ FLG_CAPS;
            end
            else if (key_code < TABLE_LEN)
            begin
                result.emit = 1'b1;
                result.key  = chr;
            end
            else
            begin
                unique case (key_code)
                    CODE_UP:
                    begin
                        result.emit = 1'b1;
                        result.key  = KEY_UP;
                    end
                    CODE_DOWN:
                    begin
                        result.emit = 1'b1;
                        result.key  = KEY_DOWN;
                    end
                    CODE_RIGHT:
                    begin
                        result.emit = 1'b1;
                        result.key  = KEY_RIGHT;
                    end
                    CODE_LEFT:
                    begin
                        result.emit = 1'b1;
                        result.key  = KEY_LEFT;
                    end
                    default:
                    begin
                        result.emit = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/scancode_to_ascii_translator.sv -----
// ============================================================================
// scancode_to_ascii_translator
// keyboard event to ascii key translator with modifier tracking
// ============================================================================
// a request is held in the input reg, then its result in the result reg
// throughput: one request per cycle unless stalled; combinational decode/lookup
// requests that give no result leave no output; caps lock still toggles its flag
// reset: async active low, clears valids, modifier flags and last key
`default_nettype none

module scancode_to_ascii_translator
    import sct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] event_type,
    input  wire logic [15:0] key_code,
    input  wire logic [7:0]  key_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [6:0]       ascii_key,
    output logic [1:0]       key_mode,
    output logic [6:0]       modifier_flags
);

    logic        s1_valid_reg;
    logic [15:0] s1_type_reg;
    logic [15:0] s1_code_reg;
    logic [7:0]  s1_value_reg;

    logic [6:0]  mods_reg;
    logic [6:0]  last_key_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  out_key_reg;
    logic [1:0]  out_mode_reg;
    logic [6:0]  out_mods_reg;

    logic        s1_advance;
    logic        s1_fire;
    sct_result_t result;

    assign s1_advance = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    sct_decode u_decode (
        .event_type (s1_type_reg),
        .key_code   (s1_code_reg),
        .key_value  (s1_value_reg),
        .mods       (mods_reg),
        .last_key   (last_key_reg),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_fire && result.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mods_reg      <= 7'h00;
            last_key_reg  <= 7'h00;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                mods_reg     <= result.mods;
                last_key_reg <= result.key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_type_reg  <= event_type;
            s1_code_reg  <= key_code;
            s1_value_reg <= key_value;
        end
        if (s1_fire && result.emit)
        begin
            out_key_reg  <= result.key;
            out_mode_reg <= result.mode;
            out_mods_reg <= result.mods;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ascii_key      = out_key_reg;
    assign key_mode       = out_mode_reg;
    assign modifier_flags = out_mods_reg;

endmodule

`default_nettype wire

// ----- sv/sct_checker.sv -----
// ============================================================================
// sct_checker
// port-level checks for the scan-code translator, bound to the top level
// ============================================================================
`default_nettype none

module sct_checker
    import sct_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [6:0]  ascii_key,
    input wire logic [1:0]  key_mode,
    input wire logic [6:0]  modifier_flags
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ascii_key)
            && $stable(key_mode) && $stable(modifier_flags))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_mode != 2'd3)
        else $error("illegal key mode");

    // letter case must agree with shift and caps flags
    a_upper_case: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_mode != MODE_NONE && ascii_key >= 7'h41 && ascii_key <= 7'h5A
            |-> (modifier_flags[0] || modifier_flags[6]))
        else $error("upper case letter without shift or caps");

    a_lower_case: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_mode != MODE_NONE && ascii_key >= 7'h61 && ascii_key <= 7'h7A
            |-> (!modifier_flags[0] && !modifier_flags[6]))
        else $error("lower case letter under shift or caps");

endmodule

bind scancode_to_ascii_translator sct_checker u_sct_checker (.*);

`default_nettype wire
